/* sv/tile_lookup_rect_table_core_defines.svh */
// Assertion macros shared by the tile lookup table RTL.
`ifndef TILE_LOOKUP_RECT_TABLE_CORE_DEFINES_SVH
`define TILE_LOOKUP_RECT_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLRT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlrt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlrt: next-cycle check failed");

`endif

/* sv/tlrt_pkg.sv */
// Types, codes and microprogram of the tile lookup table.
package tlrt_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_ADD           = 2'd0;
  localparam logic [1:0] KIND_RECT_BY_INDEX = 2'd1;
  localparam logic [1:0] KIND_RECT_BY_MASK  = 2'd2;
  localparam logic [1:0] KIND_POS_BY_MASK   = 2'd3;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHEET_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_WIDTH    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_HEIGHT   = 2'd2;

  localparam int COLS_W  = 9;
  localparam int DIM_W   = 12;
  localparam int POS_W   = 12;
  localparam int COORD_W = 24;

  // The divider produces one quotient bit per step.
  localparam int DIV_STEPS = POS_W;
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  group_id;
    logic [15:0] tile_number;
    logic [11:0] sheet_position;
    logic [15:0] neighbour_mask;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [11:0] found_position;
    logic [23:0] rect_x;
    logic [23:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
  } result_t;

  typedef struct packed {
    logic [7:0]  group_id;
    logic [15:0] tile_number;
    logic [11:0] sheet_position;
    logic [15:0] neighbour_mask;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Microprogram addresses.
  typedef enum logic [3:0] {
    STEP_FETCH,
    STEP_DISPATCH,
    STEP_ADD,
    STEP_SCAN_INIT,
    STEP_SCAN,
    STEP_CHECK,
    STEP_DIV_INIT,
    STEP_DIV,
    STEP_MUL,
    STEP_EMIT,
    STEP_EMIT_WAIT
  } step_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_APPEND,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_DIV_INIT,
    OP_DIV,
    OP_MUL,
    OP_EMIT
  } op_t;

  // Jump conditions; when false the step counter advances by one.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_LOOKUP,
    COND_SCAN_MORE,
    COND_NO_RECT,
    COND_DIV_MORE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Control store.
  function automatic ctrl_word_t ucode(step_t step);
    ctrl_word_t w;
    w.op     = OP_NOP;
    w.cond   = COND_ALWAYS;
    w.target = STEP_FETCH;
    unique case (step)
      STEP_FETCH: begin
        w.op = OP_ACCEPT; w.cond = COND_NO_ITEM; w.target = STEP_FETCH;
      end
      STEP_DISPATCH: begin
        w.op = OP_NOP; w.cond = COND_LOOKUP; w.target = STEP_SCAN_INIT;
      end
      STEP_ADD: begin
        w.op = OP_APPEND; w.cond = COND_ALWAYS; w.target = STEP_FETCH;
      end
      STEP_SCAN_INIT: begin
        w.op = OP_SCAN_INIT; w.cond = COND_ALWAYS; w.target = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.op = OP_SCAN; w.cond = COND_SCAN_MORE; w.target = STEP_SCAN;
      end
      STEP_CHECK: begin
        w.op = OP_NOP; w.cond = COND_NO_RECT; w.target = STEP_EMIT;
      end
      STEP_DIV_INIT: begin
        w.op = OP_DIV_INIT; w.cond = COND_ALWAYS; w.target = STEP_DIV;
      end
      STEP_DIV: begin
        w.op = OP_DIV; w.cond = COND_DIV_MORE; w.target = STEP_DIV;
      end
      STEP_MUL: begin
        w.op = OP_MUL; w.cond = COND_ALWAYS; w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.op = OP_EMIT; w.cond = COND_OUT_FREE; w.target = STEP_FETCH;
      end
      STEP_EMIT_WAIT: begin
        w.op = OP_NOP; w.cond = COND_ALWAYS; w.target = STEP_EMIT;
      end
      default: begin
        w.op = OP_NOP; w.cond = COND_ALWAYS; w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/tlrt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module tlrt_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/tile_lookup_rect_table_core.sv */
// Tile lookup table core: keeps up to TABLE_ENTRIES tile entries in insertion
// order and answers lookups with the sheet position and source rectangle of the
// first matching entry. Items arrive as beats on the item channel and lookup
// answers leave as beats on the result channel; an add item produces no result
// beat and a full table drops it. The block is run by a small microprogram, so
// it works on one item at a time. An add passes through fetch, dispatch and
// the append step, then returns to fetch. A lookup passes through fetch,
// dispatch and scan init, then reads one table entry per scan step, stopping
// at the first match or after the last entry, then decides in the check step.
// A miss or a position-only lookup then goes straight to emit; a rectangle
// hit first runs divider init, the divider steps and the multiply. The emit
// step retries through the emit-wait step while an earlier result beat is
// still stalled. The table memory gives one entry per cycle during the scan,
// and the divider yields one quotient bit per cycle. The result sits in an
// output register, so the next item is taken while a result beat waits.
// The table memory needs no clearing after reset: the entry count decides
// which reads can produce a match.
`include "tile_lookup_rect_table_core_defines.svh"

module tile_lookup_rect_table_core #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Item channel.
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  tlrt_pkg::item_t                      item,
  // Result channel.
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output tlrt_pkg::result_t                    result,
  // Configuration write port.
  input  logic                                 cfg_wr_en,
  input  logic [tlrt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tlrt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Count width holds TABLE_ENTRIES itself; addresses only index the table.
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  // Configuration registers.
  logic [tlrt_pkg::COLS_W-1:0] sheet_columns;
  logic [tlrt_pkg::DIM_W-1:0]  tile_width;
  logic [tlrt_pkg::DIM_W-1:0]  tile_height;

  // Sequencer.
  tlrt_pkg::step_t      pc;
  tlrt_pkg::step_t      pc_next;
  tlrt_pkg::ctrl_word_t cw;
  logic                 take_jump;

  // Datapath registers.
  tlrt_pkg::item_t             cur;
  logic [CW-1:0]               entry_count;
  logic [CW-1:0]               scan_idx;
  logic                        scan_pend;
  logic                        hit;
  logic [tlrt_pkg::POS_W-1:0]  hit_pos;
  logic [tlrt_pkg::COLS_W-1:0] divisor;
  logic [tlrt_pkg::COLS_W-1:0] rem;
  logic [tlrt_pkg::POS_W-1:0]  quo;
  logic [tlrt_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [tlrt_pkg::COORD_W-1:0] prod_x;
  logic [tlrt_pkg::COORD_W-1:0] prod_y;

  // Table memory signals.
  logic                    ram_wr_en;
  logic [AW-1:0]           ram_wr_addr;
  tlrt_pkg::entry_t        ram_wr_data;
  logic                    ram_rd_en;
  logic [AW-1:0]           ram_rd_addr;
  logic [tlrt_pkg::ENTRY_W-1:0] ram_rd_bits;
  tlrt_pkg::entry_t        rd_entry;

  // Combinational helpers.
  logic                        item_take;
  logic                        result_take;
  logic                        entry_match;
  logic                        table_has_room;
  logic [tlrt_pkg::COLS_W:0]   div_trial;
  logic [tlrt_pkg::COLS_W:0]   div_diff;
  logic                        div_ge;
  logic [20:0]                 mul_x;
  logic [23:0]                 mul_y;
  logic                        rect_ok;
  tlrt_pkg::result_t           result_next;

  // ---------------------------------------------------------------------------
  // Configuration. The user must write only while the block is idle; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_columns <= tlrt_pkg::COLS_W'(1);
      tile_width    <= '0;
      tile_height   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tlrt_pkg::CFG_SHEET_COLUMNS: sheet_columns <= cfg_data[tlrt_pkg::COLS_W-1:0];
        tlrt_pkg::CFG_TILE_WIDTH:    tile_width    <= cfg_data[tlrt_pkg::DIM_W-1:0];
        tlrt_pkg::CFG_TILE_HEIGHT:   tile_height   <= cfg_data[tlrt_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Microprogram sequencer. Each step reads one control word; the word names a
  // datapath operation and a jump condition. A false condition falls through
  // to the next step.
  // ---------------------------------------------------------------------------
  assign cw = tlrt_pkg::ucode(pc);

  // The scan compares the entry read in the previous cycle; it keeps going
  // while that entry was a live slot and did not match.
  assign rd_entry    = tlrt_pkg::entry_t'(ram_rd_bits);
  assign entry_match = (rd_entry.group_id == cur.group_id) &&
                       ((cur.kind == tlrt_pkg::KIND_RECT_BY_INDEX) ?
                        (rd_entry.tile_number == cur.tile_number) :
                        (rd_entry.neighbour_mask == cur.neighbour_mask));

  assign result_take = result_valid && !result_stall;

  always_comb begin
    unique case (cw.cond)
      tlrt_pkg::COND_ALWAYS:    take_jump = 1'b1;
      tlrt_pkg::COND_NO_ITEM:   take_jump = !item_valid;
      tlrt_pkg::COND_LOOKUP:    take_jump = (cur.kind != tlrt_pkg::KIND_ADD);
      tlrt_pkg::COND_SCAN_MORE: take_jump = scan_pend && !entry_match;
      tlrt_pkg::COND_NO_RECT:   take_jump = !hit || (cur.kind == tlrt_pkg::KIND_POS_BY_MASK);
      tlrt_pkg::COND_DIV_MORE:  take_jump = (div_cnt != tlrt_pkg::DIV_LAST);
      tlrt_pkg::COND_OUT_FREE:  take_jump = !result_valid || !result_stall;
      default:                  take_jump = 1'b0;
    endcase
  end

  always_comb begin
    if (take_jump) begin
      pc_next = cw.target;
    end else begin
      pc_next = tlrt_pkg::step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= tlrt_pkg::STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // Channel and memory controls follow the current control word.
  assign table_has_room = (entry_count < FULL_COUNT);

  always_comb begin
    item_stall  = (cw.op != tlrt_pkg::OP_ACCEPT);
    ram_wr_en   = (cw.op == tlrt_pkg::OP_APPEND) && table_has_room;
    ram_rd_en   = (cw.op == tlrt_pkg::OP_SCAN_INIT) || (cw.op == tlrt_pkg::OP_SCAN);
    ram_rd_addr = (cw.op == tlrt_pkg::OP_SCAN_INIT) ? '0 : scan_idx[AW-1:0];
  end

  assign item_take   = item_valid && !item_stall;
  assign ram_wr_addr = entry_count[AW-1:0];
  assign ram_wr_data = '{group_id:       cur.group_id,
                         tile_number:    cur.tile_number,
                         sheet_position: cur.sheet_position,
                         neighbour_mask: cur.neighbour_mask};

  tlrt_ram #(
    .WIDTH (tlrt_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_bits)
  );

  // ---------------------------------------------------------------------------
  // Restoring divider step: position div/mod columns, one quotient bit a cycle.
  // The remainder always stays below the divisor, so it fits in COLS_W bits.
  // ---------------------------------------------------------------------------
  assign div_trial = {rem, quo[tlrt_pkg::POS_W-1]};
  assign div_ge    = (div_trial >= {1'b0, divisor});
  assign div_diff  = div_trial - {1'b0, divisor};

  // Column offset times tile width, row times tile height.
  assign mul_x = rem * tile_width;
  assign mul_y = quo * tile_height;

  // ---------------------------------------------------------------------------
  // Result assembly. A miss clears everything; a position-only lookup clears
  // the rectangle fields.
  // ---------------------------------------------------------------------------
  assign rect_ok = hit && (cur.kind != tlrt_pkg::KIND_POS_BY_MASK);

  always_comb begin
    result_next.found          = hit;
    result_next.found_position = hit ? hit_pos : '0;
    result_next.rect_x         = rect_ok ? prod_x : '0;
    result_next.rect_y         = rect_ok ? prod_y : '0;
    result_next.rect_w         = rect_ok ? tile_width : '0;
    result_next.rect_h         = rect_ok ? tile_height : '0;
  end

  // ---------------------------------------------------------------------------
  // Control state: entry count and the result register's valid flag.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ram_wr_en) begin
        entry_count <= entry_count + CW'(1);
      end
      if ((cw.op == tlrt_pkg::OP_EMIT) && take_jump) begin
        result_valid <= 1'b1;
      end else if (result_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath payload registers, driven by the current operation.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (item_take) begin
      cur <= item;
    end
    if ((cw.op == tlrt_pkg::OP_EMIT) && take_jump) begin
      result <= result_next;
    end
    unique case (cw.op)
      tlrt_pkg::OP_SCAN_INIT: begin
        // Slot 0 is being read now; the next read is slot 1.
        scan_idx  <= CW'(1);
        scan_pend <= (entry_count != '0);
        hit       <= 1'b0;
      end
      tlrt_pkg::OP_SCAN: begin
        scan_idx  <= scan_idx + CW'(1);
        scan_pend <= (scan_idx < entry_count);
        hit       <= scan_pend && entry_match;
        hit_pos   <= rd_entry.sheet_position;
      end
      tlrt_pkg::OP_DIV_INIT: begin
        // A column count of zero acts as one.
        divisor <= (sheet_columns == '0) ? tlrt_pkg::COLS_W'(1) : sheet_columns;
        rem     <= '0;
        quo     <= hit_pos;
        div_cnt <= '0;
      end
      tlrt_pkg::OP_DIV: begin
        rem     <= div_ge ? div_diff[tlrt_pkg::COLS_W-1:0] :
                            div_trial[tlrt_pkg::COLS_W-1:0];
        quo     <= {quo[tlrt_pkg::POS_W-2:0], div_ge};
        div_cnt <= div_cnt + tlrt_pkg::DIV_CNT_W'(1);
      end
      tlrt_pkg::OP_MUL: begin
        prod_x <= tlrt_pkg::COORD_W'(mul_x);
        prod_y <= mul_y;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // An accepted item always moves the sequencer on to dispatch.
  `TLRT_ASSERT_NEXT(a_accept_dispatch, clk, rst, item_take, pc == tlrt_pkg::STEP_DISPATCH)
  // An add with room grows the table by exactly one entry.
  `TLRT_ASSERT_NEXT(a_append_count, clk, rst, ram_wr_en, entry_count == $past(entry_count) + CW'(1))
  // The divider keeps its remainder below the divisor.
  `TLRT_ASSERT_NEXT(a_div_rem, clk, rst, cw.op == tlrt_pkg::OP_DIV, rem < divisor)
  // A miss reports zeros in the found_position, rect_x and rect_w fields.
  `TLRT_ASSERT_SAME(a_miss_zero, clk, rst, result_valid && !result.found, (result.found_position == '0) && (result.rect_x == '0) && (result.rect_w == '0))

endmodule

/* tb/sv/tile_lookup_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts each tile lookup answer and compares it with the result beats.
module tile_lookup_checker #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  logic                                 item_stall,
  input  tlrt_pkg::item_t                      item,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  tlrt_pkg::result_t                    result,
  input  logic                                 cfg_wr_en,
  input  logic [tlrt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tlrt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int                                   pending
);
  import tlrt_pkg::*;

  entry_t            tiles [TABLE_ENTRIES];
  int unsigned       tile_count;
  logic [COLS_W-1:0] columns;
  logic [DIM_W-1:0]  tile_w;
  logic [DIM_W-1:0]  tile_h;
  result_t           answers_due [$];
  result_t           want;
  string             diffs;

  // Answer to one lookup, from the table as it stands when the beat is taken.
  function automatic result_t lookup_answer(item_t it);
    result_t         r;
    bit              hit;
    int unsigned     i;
    int unsigned     slot;
    int unsigned     cols;
    int unsigned     fpos;
    logic [15:0]     key;
    logic [15:0]     want_key;
    r = '0;
    hit = 1'b0;
    slot = 0;
    want_key = (it.kind == KIND_RECT_BY_INDEX) ? it.tile_number : it.neighbour_mask;
    for (i = 0; i < tile_count && !hit; i++) begin
      key = (it.kind == KIND_RECT_BY_INDEX) ? tiles[i].tile_number : tiles[i].neighbour_mask;
      if (tiles[i].group_id == it.group_id && key == want_key) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (!hit) return r;
    fpos = tiles[slot].sheet_position;
    r.found = 1'b1;
    r.found_position = POS_W'(fpos);
    if (it.kind == KIND_POS_BY_MASK) return r;
    // A column count of zero behaves as a single column.
    cols = (columns == '0) ? 1 : int'(columns);
    r.rect_x = COORD_W'((fpos % cols) * tile_w);
    r.rect_y = COORD_W'((fpos / cols) * tile_h);
    r.rect_w = tile_w;
    r.rect_h = tile_h;
    return r;
  endfunction

  function automatic string field_diff(string name, logic [23:0] got, logic [23:0] exp_val);
    if (got == exp_val) return "";
    return $sformatf(" %s got %0d want %0d", name, got, exp_val);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t:%s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tile_count = 0;
      columns = COLS_W'(1);
      tile_w = '0;
      tile_h = '0;
      mismatches = 0;
      answers_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SHEET_COLUMNS: columns = cfg_data[COLS_W-1:0];
          CFG_TILE_WIDTH:    tile_w = cfg_data[DIM_W-1:0];
          CFG_TILE_HEIGHT:   tile_h = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      // A result can never belong to an item taken at the same edge, so the
      // result side is handled first.
      if (result_valid && !result_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf(" result beat with no lookup outstanding: %p", result));
        end else begin
          want = answers_due.pop_front();
          diffs = {field_diff("found", result.found, want.found),
                   field_diff("found_position", result.found_position, want.found_position),
                   field_diff("rect_x", result.rect_x, want.rect_x),
                   field_diff("rect_y", result.rect_y, want.rect_y),
                   field_diff("rect_w", result.rect_w, want.rect_w),
                   field_diff("rect_h", result.rect_h, want.rect_h)};
          if (diffs != "") report_mismatch(diffs);
        end
      end
      if (item_valid && !item_stall) begin
        if (item.kind == KIND_ADD) begin
          // A full table drops the add.
          if (tile_count < TABLE_ENTRIES) begin
            tiles[tile_count] = '{group_id: item.group_id, tile_number: item.tile_number,
                                  sheet_position: item.sheet_position,
                                  neighbour_mask: item.neighbour_mask};
            tile_count++;
          end
        end else begin
          answers_due = {answers_due, lookup_answer(item)};
        end
      end
    end
    pending <= answers_due.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the tile lookup table testbench: clock, reset, stimulus and verdict.
module tb;
  import tlrt_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 100;
  // This is several times the longest quiet stretch: a lookup over a full
  // table plus the longest receiver stall and the longest item gap.
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 300;
  // An add has no result beat but keeps the block busy after it is taken.
  localparam int PHASE_PAUSE   = 16;
  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          mismatches;
  int          pending;
  // When set, neither side idles, so beats run back to back.
  bit          burst = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  // Every add sent so far, used to aim lookups at keys that exist.
  item_t       added [$];

  tile_lookup_rect_table_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tile_lookup_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result receiver: after each taken beat it draws how many cycles to stall
  // before it takes the next one. The count runs down whether or not a beat
  // is waiting, so stalls land on every phase of the block's work.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (result_valid && !result_stall) begin
      if (!burst && $urandom_range(0, 3) != 0) begin
        stall_left <= $urandom_range(1, 15);
        result_stall <= 1'b1;
      end else begin
        stall_left <= 0;
        result_stall <= 1'b0;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= (stall_left > 1);
    end
  end

  // Watchdog on cycles in which nothing at all is taken.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t make_item(logic [1:0] kind, logic [7:0] grp, logic [15:0] tnum,
                                      logic [11:0] pos, logic [15:0] mask);
    item_t it;
    it.kind = kind;
    it.group_id = grp;
    it.tile_number = tnum;
    it.sheet_position = pos;
    it.neighbour_mask = mask;
    return it;
  endfunction

  // Random item. Adds often use a few small groups and keys, so lookups meet
  // several candidates and the first match in insertion order matters. Most
  // lookups aim at a key that was added, some of them one bit off.
  function automatic item_t random_tile_item(int unsigned add_pct);
    item_t       it;
    item_t       src;
    int unsigned pick;
    it.group_id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    it.tile_number = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    it.sheet_position = 12'($urandom);
    it.neighbour_mask = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    if ($urandom_range(0, 99) < add_pct) begin
      it.kind = KIND_ADD;
      return it;
    end
    pick = $urandom_range(0, 2);
    it.kind = (pick == 0) ? KIND_RECT_BY_INDEX : (pick == 1) ? KIND_RECT_BY_MASK : KIND_POS_BY_MASK;
    if (added.size() != 0 && $urandom_range(0, 99) < 70) begin
      src = added[$urandom_range(0, added.size() - 1)];
      it.group_id = src.group_id;
      it.tile_number = src.tile_number;
      it.neighbour_mask = src.neighbour_mask;
      if ($urandom_range(0, 99) < 15) begin
        pick = $urandom_range(0, 15);
        if ($urandom_range(0, 1) == 0) it.group_id[pick % 8] = ~it.group_id[pick % 8];
        else if (it.kind == KIND_RECT_BY_INDEX) it.tile_number[pick] = ~it.tile_number[pick];
        else it.neighbour_mask[pick] = ~it.neighbour_mask[pick];
      end
    end
    return it;
  endfunction

  // Sends one item beat after a drawn gap. Valid stays high across a zero
  // gap, so it is never lowered and raised within one time step.
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (it.kind == KIND_ADD) added = {added, it};
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Writes all three registers back to back, and optionally the unused index.
  task automatic apply_settings(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] w,
                                logic [CFG_DATA_W-1:0] h, bit poke_unused);
    write_reg(CFG_SHEET_COLUMNS, cols);
    write_reg(CFG_TILE_WIDTH, w);
    write_reg(CFG_TILE_HEIGHT, h);
    if (poke_unused) write_reg(CFG_UNUSED, 12'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every lookup has been answered and the block has had time to
  // finish a trailing add. The pending count is registered, so the first
  // edge is skipped to see the count that includes the last beat.
  task automatic drain(int unsigned extra);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Zero columns must act as one column; full-size tiles.
    apply_settings(12'd0, 12'd4095, 12'd4095, 1'b0);
    // Lookups of every kind on an empty table miss.
    send_item(make_item(KIND_RECT_BY_INDEX, 8'd0, 16'd0, 12'd0, 16'd0));
    send_item(make_item(KIND_RECT_BY_MASK, 8'd255, 16'hFFFF, 12'hFFF, 16'hFFFF));
    send_item(make_item(KIND_POS_BY_MASK, 8'd0, 16'd0, 12'd0, 16'd0));
    // Extremes, a duplicate key that must lose to the older entry, and a
    // checkerboard entry.
    send_item(make_item(KIND_ADD, 8'd0, 16'd0, 12'd0, 16'd0));
    send_item(make_item(KIND_ADD, 8'd255, 16'hFFFF, 12'hFFF, 16'hFFFF));
    send_item(make_item(KIND_ADD, 8'd255, 16'hFFFF, 12'd17, 16'hFFFF));
    send_item(make_item(KIND_ADD, 8'd7, 16'hA5A5, 12'h5A5, 16'h5A5A));
    send_item(make_item(KIND_RECT_BY_INDEX, 8'd0, 16'd0, 12'hFFF, 16'hFFFF));
    send_item(make_item(KIND_RECT_BY_INDEX, 8'd255, 16'hFFFF, 12'd0, 16'd0));
    send_item(make_item(KIND_RECT_BY_MASK, 8'd255, 16'h0, 12'd0, 16'hFFFF));
    send_item(make_item(KIND_POS_BY_MASK, 8'd255, 16'h0, 12'd0, 16'hFFFF));
    // Right key in the wrong group, and a tile index used as a mask: misses. Then mask hits.
    send_item(make_item(KIND_RECT_BY_INDEX, 8'd255, 16'd0, 12'd0, 16'd0));
    send_item(make_item(KIND_RECT_BY_MASK, 8'd7, 16'h5A5A, 12'd0, 16'hA5A5));
    send_item(make_item(KIND_RECT_BY_MASK, 8'd7, 16'h0, 12'd0, 16'h5A5A));
    send_item(make_item(KIND_POS_BY_MASK, 8'd7, 16'h0, 12'd0, 16'h5A5A));
    send_item(make_item(KIND_RECT_BY_MASK, 8'd0, 16'hFFFF, 12'd0, 16'd0));
    drain(PHASE_PAUSE);

    // Column count above the sheet width range, zero height, and a write to
    // the unused index that must change nothing.
    apply_settings(12'd511, 12'd4095, 12'd0, 1'b1);
    send_item(make_item(KIND_RECT_BY_INDEX, 8'd255, 16'hFFFF, 12'd0, 16'd0));
    send_item(make_item(KIND_RECT_BY_INDEX, 8'd7, 16'hA5A5, 12'd0, 16'd0));
    send_item(make_item(KIND_RECT_BY_MASK, 8'd0, 16'd0, 12'd0, 16'd0));
    send_item(make_item(KIND_POS_BY_MASK, 8'd7, 16'd0, 12'd0, 16'h5A5A));

    // Random phases, each under its own settings. Early phases add more, so
    // the table fills and later adds are dropped against a full table.
    for (int p = 0; p < PHASES; p++) begin
      drain(PHASE_PAUSE);
      case (p)
        0:       apply_settings(12'd256, 12'd4095, 12'd4095, 1'b0);
        1:       apply_settings(12'd1, 12'd0, 12'd4095, 1'b0);
        2:       apply_settings(12'd256, 12'd4095, 12'd0, 1'b1);
        3:       apply_settings(12'd1, 12'd1, 12'd1, 1'b0);
        default: apply_settings(12'($urandom), 12'($urandom), 12'($urandom), p[0]);
      endcase
      burst = (p % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_tile_item((p < 4) ? 50 : 30));
      end
    end

    drain(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
